// File: sv/plcms_pkg.sv
// Package for the pulse-count LED mode sender.
// Holds transaction structs, command and phase codes, and sizing constants.
// No dependencies.
`default_nettype none

package plcms_pkg;

    // Sizing
    localparam int TICK_WIDTH_DEF = 20;
    localparam int CFG_W          = 20;
    localparam int CFG_IDX_W      = 3;
    localparam int KIND_W         = 3;
    localparam int BRIGHT_W       = 8;
    localparam int MODE_W         = 4;
    localparam int QUEUE_DEPTH    = 2;

    // Frame codes and mode limit
    localparam logic [MODE_W-1:0] CODE_INIT = 4'd11;
    localparam logic [MODE_W-1:0] MODE_TOP  = 4'd9;

    // Reset values of the timing registers
    localparam logic [CFG_W-1:0] LEAD_RST   = 20'd1000;
    localparam logic [CFG_W-1:0] SYNC_RST   = 20'd6000;
    localparam logic [CFG_W-1:0] PULSE_RST  = 20'd1000;
    localparam logic [CFG_W-1:0] END_RST    = 20'd5000;
    localparam logic [CFG_W-1:0] SETTLE_RST = 20'd100000;

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BUTTON  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEAD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd4;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_BUTTON,
        CMD_SET,
        CMD_SUSPEND,
        CMD_RESUME,
        CMD_NONE
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_LEAD,
        PH_SYNC,
        PH_GAP,
        PH_HIGH,
        PH_LOW,
        PH_END
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BRIGHT_W-1:0] brightness;
    } item_t;

    typedef struct packed {
        logic              ctrl_level;
        logic              enable_level;
        logic              busy_res;
        logic              accepted;
        logic [MODE_W-1:0] mode_now;
    } result_t;

    // Classified command as it waits between front and engine
    typedef struct packed {
        cmd_t              cmd;
        logic [MODE_W-1:0] level;
    } entry_t;

endpackage

`default_nettype wire

// File: sv/plcms_fifo.sv
// Small register queue used between the front and the engine and on the result side.
// Depends on plcms_pkg for the default depth.
`default_nettype none

module plcms_fifo #(
    parameter int DEPTH = plcms_pkg::QUEUE_DEPTH,
    parameter type data_t = logic
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        push,
    input  wire data_t wr_data,
    output logic       full,
    input  wire        pop,
    output data_t      rd_data,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    data_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/plcms_front.sv
// Front of the sender: takes input transactions, classifies them and queues them.
// Depends on plcms_pkg and plcms_fifo.
`default_nettype none

module plcms_front (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  wire plcms_pkg::item_t   item,
    output logic                    full,
    input  wire                     entry_pop,
    output plcms_pkg::entry_t       entry,
    output logic                    entry_valid
);

    plcms_pkg::entry_t decoded;
    logic              entry_empty;

    // Classify the kind and clamp the requested level
    always_comb
    begin
        case (item.kind)
            plcms_pkg::KIND_TICK:    decoded.cmd = plcms_pkg::CMD_TICK;
            plcms_pkg::KIND_BUTTON:  decoded.cmd = plcms_pkg::CMD_BUTTON;
            plcms_pkg::KIND_SET:     decoded.cmd = plcms_pkg::CMD_SET;
            plcms_pkg::KIND_SUSPEND: decoded.cmd = plcms_pkg::CMD_SUSPEND;
            plcms_pkg::KIND_RESUME:  decoded.cmd = plcms_pkg::CMD_RESUME;
            default:                 decoded.cmd = plcms_pkg::CMD_NONE;
        endcase
        if (item.brightness > plcms_pkg::BRIGHT_W'(plcms_pkg::MODE_TOP))
        begin
            decoded.level = plcms_pkg::MODE_TOP;
        end
        else
        begin
            decoded.level = item.brightness[plcms_pkg::MODE_W-1:0];
        end
    end

    plcms_fifo #(
        .DEPTH  (plcms_pkg::QUEUE_DEPTH),
        .data_t (plcms_pkg::entry_t)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (decoded),
        .full    (full),
        .pop     (entry_pop),
        .rd_data (entry),
        .empty   (entry_empty)
    );

    assign entry_valid = !entry_empty;

endmodule

`default_nettype wire

// File: sv/plcms_engine.sv
// Back end of the sender: timing registers, frame phase sequencer and mode state.
// Depends on plcms_pkg.
`default_nettype none

module plcms_engine #(
    parameter int TICK_WIDTH = plcms_pkg::TICK_WIDTH_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [plcms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [plcms_pkg::CFG_W-1:0]          cfg_data,
    input  wire                                  entry_valid,
    input  wire plcms_pkg::entry_t               entry,
    output logic                                 entry_pop,
    input  wire                                  res_full,
    output logic                                 res_push,
    output plcms_pkg::result_t                   res
);

    localparam int CW = plcms_pkg::CFG_W;
    localparam int MW = plcms_pkg::MODE_W;
    localparam int LW = (TICK_WIDTH > CW) ? TICK_WIDTH : CW;
    localparam logic [LW-1:0] LEN_CAP = LW'({TICK_WIDTH{1'b1}});

    // Timing registers
    logic [CW-1:0] lead_reg, sync_reg, pulse_reg, end_reg, settle_reg;

    // Sequencer state
    plcms_pkg::phase_t     phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [MW-1:0]         pulses_reg, pulses_next;
    logic [MW-1:0]         mode_reg, mode_next;
    logic                  enable_reg, enable_next;
    logic                  follow_reg, follow_next;
    logic                  drop_reg, drop_next;

    logic [CW-1:0] len_raw, len_nz;
    logic [LW-1:0] len_ext, len;
    logic [LW:0]   tick_plus;
    logic          len_done;
    logic          accepted;
    logic          step;
    logic [MW-1:0] mode_inc, pulses_dec;

    assign cfg_ready = 1'b1;
    assign step      = entry_valid && !res_full;
    assign entry_pop = step;
    assign res_push  = step;

    // Write timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= plcms_pkg::LEAD_RST;
            sync_reg   <= plcms_pkg::SYNC_RST;
            pulse_reg  <= plcms_pkg::PULSE_RST;
            end_reg    <= plcms_pkg::END_RST;
            settle_reg <= plcms_pkg::SETTLE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                plcms_pkg::REG_LEAD:   lead_reg   <= cfg_data;
                plcms_pkg::REG_SYNC:   sync_reg   <= cfg_data;
                plcms_pkg::REG_PULSE:  pulse_reg  <= cfg_data;
                plcms_pkg::REG_END:    end_reg    <= cfg_data;
                plcms_pkg::REG_SETTLE: settle_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pick the length of the running phase, force at least one tick, cap to counter range
    always_comb
    begin
        case (phase_reg)
            plcms_pkg::PH_SETTLE: len_raw = settle_reg;
            plcms_pkg::PH_LEAD:   len_raw = lead_reg;
            plcms_pkg::PH_SYNC:   len_raw = sync_reg;
            plcms_pkg::PH_GAP,
            plcms_pkg::PH_HIGH,
            plcms_pkg::PH_LOW:    len_raw = pulse_reg;
            default:              len_raw = end_reg;
        endcase
        len_nz    = (len_raw == '0) ? CW'(1) : len_raw;
        len_ext   = LW'(len_nz);
        len       = (len_ext > LEN_CAP) ? LEN_CAP : len_ext;
        tick_plus = (LW + 1)'(tick_reg) + (LW + 1)'(1);
        len_done  = !(tick_plus < {1'b0, len});
    end

    assign mode_inc   = (mode_reg == plcms_pkg::MODE_TOP) ? '0 : mode_reg + 1'b1;
    assign pulses_dec = (pulses_reg != '0) ? pulses_reg - 1'b1 : pulses_reg;

    // Next state: tick the sequencer or start a command when idle
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        pulses_next = pulses_reg;
        mode_next   = mode_reg;
        enable_next = enable_reg;
        follow_next = follow_reg;
        drop_next   = drop_reg;
        accepted    = 1'b0;
        if (entry.cmd == plcms_pkg::CMD_TICK)
        begin
            if (phase_reg != plcms_pkg::PH_IDLE)
            begin
                if (!len_done)
                begin
                    tick_next = tick_plus[TICK_WIDTH-1:0];
                end
                else
                begin
                    tick_next = '0;
                    case (phase_reg)
                        plcms_pkg::PH_SETTLE:
                        begin
                            phase_next  = plcms_pkg::PH_LEAD;
                            pulses_next = plcms_pkg::CODE_INIT;
                        end
                        plcms_pkg::PH_LEAD: phase_next = plcms_pkg::PH_SYNC;
                        plcms_pkg::PH_SYNC: phase_next = plcms_pkg::PH_GAP;
                        plcms_pkg::PH_GAP:
                        begin
                            phase_next = (pulses_reg != '0) ? plcms_pkg::PH_HIGH
                                                            : plcms_pkg::PH_END;
                        end
                        plcms_pkg::PH_HIGH: phase_next = plcms_pkg::PH_LOW;
                        plcms_pkg::PH_LOW:
                        begin
                            pulses_next = pulses_dec;
                            phase_next  = (pulses_dec != '0) ? plcms_pkg::PH_HIGH
                                                             : plcms_pkg::PH_END;
                        end
                        default:
                        begin
                            // End of frame: drop enable, chain the kept mode, or stop
                            phase_next = plcms_pkg::PH_IDLE;
                            if (drop_reg)
                            begin
                                enable_next = 1'b0;
                                drop_next   = 1'b0;
                            end
                            else if (follow_reg)
                            begin
                                follow_next = 1'b0;
                                if (mode_reg != '0)
                                begin
                                    phase_next  = plcms_pkg::PH_LEAD;
                                    pulses_next = mode_reg;
                                end
                            end
                        end
                    endcase
                end
            end
        end
        else if (phase_reg == plcms_pkg::PH_IDLE && entry.cmd != plcms_pkg::CMD_NONE)
        begin
            accepted   = 1'b1;
            tick_next  = '0;
            phase_next = plcms_pkg::PH_LEAD;
            case (entry.cmd)
                plcms_pkg::CMD_BUTTON:
                begin
                    mode_next   = mode_inc;
                    pulses_next = (mode_inc == '0) ? plcms_pkg::CODE_INIT : mode_inc;
                end
                plcms_pkg::CMD_SET:
                begin
                    mode_next   = entry.level;
                    pulses_next = (entry.level == '0) ? plcms_pkg::CODE_INIT : entry.level;
                end
                plcms_pkg::CMD_SUSPEND:
                begin
                    drop_next   = 1'b1;
                    follow_next = 1'b0;
                    pulses_next = plcms_pkg::CODE_INIT;
                end
                default:
                begin
                    // Resume: raise enable, settle unless its length is zero, then init and any kept mode
                    enable_next = 1'b1;
                    drop_next   = 1'b0;
                    follow_next = (mode_reg != '0);
                    pulses_next = plcms_pkg::CODE_INIT;
                    if (settle_reg != '0)
                    begin
                        phase_next = plcms_pkg::PH_SETTLE;
                    end
                end
            endcase
        end
    end

    // Build the result from the updated state
    always_comb
    begin
        res.ctrl_level   = (phase_next == plcms_pkg::PH_SYNC) ||
                           (phase_next == plcms_pkg::PH_HIGH);
        res.enable_level = enable_next;
        res.busy_res     = (phase_next != plcms_pkg::PH_IDLE);
        res.accepted     = accepted;
        res.mode_now     = mode_next;
    end

    // Hold state unless a transaction is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= plcms_pkg::PH_IDLE;
            tick_reg   <= '0;
            pulses_reg <= '0;
            mode_reg   <= '0;
            enable_reg <= 1'b1;
            follow_reg <= 1'b0;
            drop_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            pulses_reg <= pulses_next;
            mode_reg   <= mode_next;
            enable_reg <= enable_next;
            follow_reg <= follow_next;
            drop_reg   <= drop_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/pulse_count_led_mode_sender.sv
// Top level of the pulse-count LED mode sender.
// Depends on plcms_pkg, plcms_front, plcms_engine and plcms_fifo.
//
// Usage:
//   Input queue: drive item (kind, brightness) and raise push; the transaction
//   is taken on a clock edge with push high and full low. Kind 0 is one
//   microsecond tick, kinds 1..4 are button, brightness set, suspend, resume.
//   Result queue: while empty is low, result holds the oldest result; pop it
//   on an edge with pop high. Every input transaction yields one result.
//   Configuration: cfg_valid with cfg_index/cfg_data; cfg_ready is always
//   high. Write only while no transaction is in flight.
// Timing:
//   A pushed transaction waits in the command queue, is processed in one engine
//   step and is written to the result queue, from which it can then be popped.
//   One transaction is taken per cycle while the result queue has room, each
//   one a step of the phase sequencer. Each queue holds two entries.
// Reset: timing registers take their defaults, the wire idles low, enable
//   is high, mode is off, both queues are empty.
// Stall: when pop stays low the result queue fills, the engine holds, and
//   full rises once the command queue is full too; nothing is lost.
`default_nettype none

module pulse_count_led_mode_sender #(
    parameter int TICK_WIDTH = plcms_pkg::TICK_WIDTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              push,
    input  wire plcms_pkg::item_t            item,
    output logic                             full,
    output logic                             empty,
    input  wire                              pop,
    output plcms_pkg::result_t               result,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [plcms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [plcms_pkg::CFG_W-1:0]      cfg_data
);

    plcms_pkg::entry_t  entry;
    plcms_pkg::result_t res;
    logic               entry_valid, entry_pop;
    logic               res_push, res_full;

    plcms_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .item        (item),
        .full        (full),
        .entry_pop   (entry_pop),
        .entry       (entry),
        .entry_valid (entry_valid)
    );

    plcms_engine #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .entry_valid (entry_valid),
        .entry       (entry),
        .entry_pop   (entry_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (res)
    );

    plcms_fifo #(
        .DEPTH  (plcms_pkg::QUEUE_DEPTH),
        .data_t (plcms_pkg::result_t)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

    // Engine never writes a result into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result written into full queue");

    // A taken command always starts a settle wait or a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.accepted) |-> result.busy_res)
        else $error("accepted command left sender idle");

    // The control wire stays low whenever the sender is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.busy_res) |-> !result.ctrl_level)
        else $error("control wire high while idle");

endmodule

`default_nettype wire

// File: tb/sv/pulse_count_led_mode_sender_checker.sv
// Checker for the pulse-count LED mode sender: follows the input, result and
// timing-register channels, predicts the wire levels and compares them.
// Depends on plcms_pkg.
module pulse_count_led_mode_sender_checker #(
    parameter int TICK_WIDTH = plcms_pkg::TICK_WIDTH_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             push,
    input  plcms_pkg::item_t                item,
    input  wire                             full,
    input  wire                             empty,
    input  wire                             pop,
    input  plcms_pkg::result_t              result,
    input  wire                             cfg_valid,
    input  wire                             cfg_ready,
    input  wire [plcms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [plcms_pkg::CFG_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              cmds_taken,
    output logic                            frame_busy
);
    import plcms_pkg::*;

    localparam logic [63:0] COUNT_MAX = (64'd1 << TICK_WIDTH) - 64'd1;

    // Timing registers as last written
    logic [CFG_W-1:0] lead_len;
    logic [CFG_W-1:0] sync_len;
    logic [CFG_W-1:0] pulse_len;
    logic [CFG_W-1:0] tail_len;
    logic [CFG_W-1:0] settle_len;

    // Predicted sender state
    phase_t                wire_phase;
    logic [TICK_WIDTH-1:0] phase_count;
    logic [MODE_W-1:0]     kept_mode;
    logic [MODE_W-1:0]     pulses_left;
    logic                  enable_on;
    logic                  follow_mode;
    logic                  drop_after;

    // Wire levels predicted for accepted input, oldest first
    result_t levels_due[$];
    int      mismatches;
    int      checked;

    assign frame_busy = (wire_phase != PH_IDLE);

    // Length of a phase in ticks; zero acts as one, and the count width caps it
    function automatic logic [63:0] span_of(input phase_t ph);
        logic [63:0] d;
        case (ph)
            PH_SETTLE:               d = settle_len;
            PH_LEAD:                 d = lead_len;
            PH_SYNC:                 d = sync_len;
            PH_GAP, PH_HIGH, PH_LOW: d = pulse_len;
            default:                 d = tail_len;
        endcase
        if (d == 64'd0)
            d = 64'd1;
        if (d > COUNT_MAX)
            d = COUNT_MAX;
        return d;
    endfunction

    task automatic enter_phase(input phase_t ph);
        wire_phase  = ph;
        phase_count = '0;
    endtask

    task automatic launch_frame(input logic [MODE_W-1:0] code);
        pulses_left = code;
        enter_phase(PH_LEAD);
    endtask

    // Frame over: drop enable after suspend, or chain the kept mode after resume
    task automatic close_frame();
        if (drop_after)
        begin
            enable_on  = 1'b0;
            drop_after = 1'b0;
            enter_phase(PH_IDLE);
        end
        else if (follow_mode)
        begin
            follow_mode = 1'b0;
            if (kept_mode != '0)
                launch_frame(kept_mode);
            else
                enter_phase(PH_IDLE);
        end
        else
        begin
            enter_phase(PH_IDLE);
        end
    endtask

    // Advance one tick of wire time
    task automatic count_tick();
        logic [63:0] next_count;
        next_count = 64'd1;
        next_count = next_count + phase_count;
        if (wire_phase != PH_IDLE)
        begin
            if (next_count < span_of(wire_phase))
            begin
                phase_count = phase_count + 1'b1;
            end
            else
            begin
                case (wire_phase)
                    PH_SETTLE: launch_frame(CODE_INIT);
                    PH_LEAD:   enter_phase(PH_SYNC);
                    PH_SYNC:   enter_phase(PH_GAP);
                    PH_GAP:
                    begin
                        if (pulses_left != '0)
                            enter_phase(PH_HIGH);
                        else
                            enter_phase(PH_END);
                    end
                    PH_HIGH:   enter_phase(PH_LOW);
                    PH_LOW:
                    begin
                        if (pulses_left != '0)
                            pulses_left = pulses_left - 1'b1;
                        if (pulses_left != '0)
                            enter_phase(PH_HIGH);
                        else
                            enter_phase(PH_END);
                    end
                    default:   close_frame();
                endcase
            end
        end
    endtask

    // Apply one input transaction and work out the levels it leaves
    task automatic step_sender(input item_t it, output result_t levels);
        logic              took;
        logic [MODE_W-1:0] next_mode;
        took = 1'b0;
        if (it.kind == KIND_TICK)
        begin
            count_tick();
        end
        else if (wire_phase == PH_IDLE && it.kind <= KIND_RESUME)
        begin
            took = 1'b1;
            case (it.kind)
                KIND_BUTTON:
                begin
                    next_mode = kept_mode + 1'b1;
                    if (next_mode > MODE_TOP)
                        next_mode = '0;
                    kept_mode = next_mode;
                    launch_frame(next_mode == '0 ? CODE_INIT : next_mode);
                end
                KIND_SET:
                begin
                    if (it.brightness == '0)
                    begin
                        kept_mode = '0;
                        launch_frame(CODE_INIT);
                    end
                    else
                    begin
                        if (it.brightness > MODE_TOP)
                            kept_mode = MODE_TOP;
                        else
                            kept_mode = it.brightness[MODE_W-1:0];
                        launch_frame(kept_mode);
                    end
                end
                KIND_SUSPEND:
                begin
                    drop_after  = 1'b1;
                    follow_mode = 1'b0;
                    launch_frame(CODE_INIT);
                end
                default:
                begin
                    enable_on   = 1'b1;
                    drop_after  = 1'b0;
                    follow_mode = (kept_mode != '0);
                    if (settle_len == '0)
                        launch_frame(CODE_INIT);
                    else
                        enter_phase(PH_SETTLE);
                end
            endcase
        end
        if (took)
            cmds_taken++;
        levels.ctrl_level   = (wire_phase == PH_SYNC || wire_phase == PH_HIGH);
        levels.enable_level = enable_on;
        levels.busy_res     = (wire_phase != PH_IDLE);
        levels.accepted     = took;
        levels.mode_now     = kept_mode;
    endtask

    task automatic note_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
        if (want_v != got_v)
        begin
            fail_count++;
            if (mismatches < 10)
                $display("mismatch on %s in result %0d: expected %0d, got %0d",
                         name, checked, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        if (!rst_n)
        begin
            lead_len    = LEAD_RST;
            sync_len    = SYNC_RST;
            pulse_len   = PULSE_RST;
            tail_len    = END_RST;
            settle_len  = SETTLE_RST;
            wire_phase  = PH_IDLE;
            phase_count = '0;
            kept_mode   = '0;
            pulses_left = '0;
            enable_on   = 1'b1;
            follow_mode = 1'b0;
            drop_after  = 1'b0;
            levels_due.delete();
            mismatches  = 0;
            checked     = 0;
            fail_count  = 0;
            pending     = 0;
            cmds_taken  = 0;
        end
        else
        begin
            // Compare a popped result with the oldest prediction
            if (pop && !empty)
            begin
                if (levels_due.size() == 0)
                begin
                    fail_count++;
                    if (mismatches < 10)
                        $display("result with nothing expected: %b", result);
                    mismatches++;
                end
                else
                begin
                    want = levels_due.pop_front();
                    note_field("ctrl_level", want.ctrl_level, result.ctrl_level);
                    note_field("enable_level", want.enable_level, result.enable_level);
                    note_field("busy_res", want.busy_res, result.busy_res);
                    note_field("accepted", want.accepted, result.accepted);
                    note_field("mode_now", want.mode_now, result.mode_now);
                end
                checked++;
            end
            // Track timing register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEAD:   lead_len   = cfg_data;
                    REG_SYNC:   sync_len   = cfg_data;
                    REG_PULSE:  pulse_len  = cfg_data;
                    REG_END:    tail_len   = cfg_data;
                    REG_SETTLE: settle_len = cfg_data;
                    default:    ;
                endcase
            end
            // Predict the levels for an accepted input transaction
            if (push && !full)
            begin
                step_sender(item, want);
                levels_due.push_back(want);
            end
            pending = levels_due.size();
        end
    end

endmodule

// File: tb/sv/pulse_count_led_mode_sender_tb.sv
// Testbench top for the pulse-count LED mode sender: drives input and timing
// transactions, drains results at random, and gives the verdict.
// Depends on plcms_pkg, the sender RTL and pulse_count_led_mode_sender_checker.
module pulse_count_led_mode_sender_tb;
    import plcms_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int PAUSE_CYCLES  = 4;
    localparam int TAIL_CYCLES   = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 70;
    localparam int RANDOM_PHASES = 6;

    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = KIND_RESUME + 1'b1;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = '1;
    localparam logic [CFG_W-1:0]  LEN_MAX           = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    item_t                feed;
    logic                 full;
    logic                 empty;
    logic                 pop;
    result_t              levels;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int   fail_count;
    int   pending;
    int   cmds_taken;
    logic frame_busy;

    int unsigned tx_gap_max  = 16;
    int unsigned rx_gap_max  = 16;
    int unsigned rx_wait     = 0;
    int unsigned rx_hold     = 0;
    int          items_sent  = 0;
    int          popped      = 0;
    int          setups      = 0;
    int          full_stalls = 0;
    logic        timed_out   = 1'b0;

    pulse_count_led_mode_sender dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (feed),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (levels),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pulse_count_led_mode_sender_checker levels_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (feed),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .result     (levels),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .cmds_taken (cmds_taken),
        .frame_busy (frame_busy)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Count full stalls; after each popped transaction draw the next wait
    always @(posedge clk)
    begin
        if (push && full)
            full_stalls++;
        if (pop && !empty)
        begin
            popped++;
            rx_wait = $urandom_range(0, rx_gap_max);
            if (popped % 50 == 0)
                rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            if (popped == 150 || popped == 600)
                rx_hold = HOLD_CYCLES;
        end
    end

    // Result side: hold off for the drawn wait or a long hold, else pop
    initial
    begin : drain_results
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold != 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (rx_wait != 0)
            begin
                rx_wait--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= rst_n;
            end
        end
    end

    // Offer one input transaction after a random gap; return at the next falling edge
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        feed <= it;
        do @(posedge clk); while (full);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_cmd(input logic [KIND_W-1:0] kind,
                            input logic [BRIGHT_W-1:0] level);
        item_t it;
        it.kind       = kind;
        it.brightness = level;
        send_item(it);
    endtask

    task automatic send_tick();
        send_cmd(KIND_TICK, BRIGHT_W'($urandom_range(0, 255)));
    endtask

    // Tick until the predicted frame or settle wait is over
    task automatic finish_frame();
        while (frame_busy)
            send_tick();
    endtask

    // Stop offering and wait for every predicted result to come out
    task automatic wait_drained();
        push <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Reprogram all timing registers once the block is idle and drained
    task automatic program_timing(input logic [CFG_W-1:0] lead_v,
                                  input logic [CFG_W-1:0] sync_v,
                                  input logic [CFG_W-1:0] pulse_v,
                                  input logic [CFG_W-1:0] tail_v,
                                  input logic [CFG_W-1:0] settle_v);
        finish_frame();
        wait_drained();
        repeat (PAUSE_CYCLES) @(negedge clk);
        write_reg(REG_LEAD, lead_v);
        write_reg(REG_SYNC, sync_v);
        write_reg(REG_PULSE, pulse_v);
        write_reg(REG_END, tail_v);
        write_reg(REG_SETTLE, settle_v);
        cfg_valid <= 1'b0;
        setups++;
    endtask

    // Mostly short lengths; now and then a longer one
    function automatic logic [CFG_W-1:0] pick_len(input logic long_ok);
        if (long_ok && $urandom_range(0, 3) == 0)
            return CFG_W'($urandom_range(20, 40));
        return CFG_W'($urandom_range(0, 6));
    endfunction

    function automatic item_t random_command();
        item_t it;
        case ($urandom_range(0, 4))
            0:       it.kind = KIND_BUTTON;
            1, 2:    it.kind = KIND_SET;
            3:       it.kind = KIND_SUSPEND;
            default: it.kind = KIND_RESUME;
        endcase
        it.brightness = BRIGHT_W'($urandom_range(0, 255));
        if (it.kind == KIND_SET)
        begin
            case ($urandom_range(0, 9))
                0:       it.brightness = '0;
                1, 2:    it.brightness = BRIGHT_W'($urandom_range(10, 255));
                default: it.brightness = BRIGHT_W'($urandom_range(1, 9));
            endcase
        end
        return it;
    endfunction

    // One command, then either a full frame of ticks or a cut-short run
    task automatic run_episode();
        int unsigned cut;
        send_item(random_command());
        if ($urandom_range(0, 9) < 6)
        begin
            finish_frame();
        end
        else
        begin
            cut = $urandom_range(0, 20);
            repeat (cut) send_tick();
        end
        if ($urandom_range(0, 6) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                send_cmd(KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)),
                         BRIGHT_W'($urandom_range(0, 255)));
            else
                send_item(random_command());
        end
    endtask

    task automatic drive_all();
        int   p;
        int   first;
        logic paused;

        // Reset timing: only ticks and unused kinds, so the block stays idle
        repeat (4) send_tick();
        send_cmd(KIND_UNUSED_FIRST, '1);
        send_cmd(KIND_UNUSED_LAST, '0);

        // Short frames for the directed part
        program_timing(20'd1, 20'd2, 20'd1, 20'd1, 20'd3);
        send_tick();
        // Brightness off, lowest, top, just above top and the field maximum
        send_cmd(KIND_SET, 8'd0);
        finish_frame();
        send_cmd(KIND_SET, 8'd1);
        finish_frame();
        send_cmd(KIND_SET, 8'd9);
        finish_frame();
        send_cmd(KIND_SET, 8'd10);
        finish_frame();
        send_cmd(KIND_SET, 8'hFF);
        finish_frame();
        // Step past the top mode: wrap to off, then to the first mode
        send_cmd(KIND_BUTTON, '0);
        finish_frame();
        send_cmd(KIND_BUTTON, '0);
        finish_frame();
        // Refuse every command while a frame runs
        send_cmd(KIND_SET, 8'd5);
        send_cmd(KIND_BUTTON, '0);
        send_tick();
        send_cmd(KIND_SUSPEND, '0);
        send_cmd(KIND_RESUME, '0);
        send_cmd(KIND_UNUSED_FIRST, '0);
        send_cmd(KIND_SET, 8'd2);
        finish_frame();
        send_cmd(KIND_UNUSED_LAST, 8'h55);
        // Suspend drops enable after its init frame, also when already low
        send_cmd(KIND_SUSPEND, '0);
        finish_frame();
        send_tick();
        send_cmd(KIND_SUSPEND, '0);
        finish_frame();
        // Resume with a kept mode: settle, init, then the mode; refuse a press meanwhile
        send_cmd(KIND_RESUME, '0);
        send_cmd(KIND_BUTTON, '0);
        finish_frame();
        // Resume with mode off sends only init
        send_cmd(KIND_SET, 8'd0);
        finish_frame();
        send_cmd(KIND_SUSPEND, '0);
        finish_frame();
        send_cmd(KIND_RESUME, '0);
        finish_frame();

        // Zero lengths act as one tick; resume starts its init frame at once
        program_timing('0, '0, '0, '0, '0);
        send_cmd(KIND_SET, 8'd3);
        finish_frame();
        send_cmd(KIND_RESUME, '0);
        finish_frame();
        send_cmd(KIND_BUTTON, '0);
        finish_frame();

        // Random phases, each under its own timing
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                program_timing(20'd1, 20'd1, 20'd1, 20'd1, 20'd1);
            else
                program_timing(pick_len(1'b1), pick_len(1'b1), pick_len(1'b0),
                               pick_len(1'b0), pick_len(1'b1));
            tx_gap_max = (p % 3 == 2) ? 0 : 16;
            first      = items_sent;
            paused     = 1'b0;
            while (items_sent - first < PHASE_ITEMS)
            begin
                run_episode();
                // Pause halfway until every result is out
                if (!paused && items_sent - first >= PHASE_ITEMS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        // Largest lengths: stay idle, no frame is started
        tx_gap_max = 16;
        program_timing(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
        repeat (6) send_tick();
        send_cmd(KIND_UNUSED_LAST, BRIGHT_W'($urandom_range(0, 255)));

        finish_frame();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Give up when no transaction moves for too long
    task automatic watch_progress();
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        timed_out = 1'b1;
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    endtask

    initial
    begin : main
        rst_n     = 1'b0;
        push      = 1'b0;
        feed      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        fork
            drive_all();
            watch_progress();
        join_any

        $display("Run covered %0d input transactions, %0d commands taken, %0d timing setups.",
                 items_sent, cmds_taken, setups);
        $display("%0d results drained; input held off by a full queue on %0d cycles.",
                 popped, full_stalls);
        if (!timed_out && fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/plcms_pkg.sv
sv/plcms_fifo.sv
sv/plcms_front.sv
sv/plcms_engine.sv
sv/pulse_count_led_mode_sender.sv
tb/sv/pulse_count_led_mode_sender_checker.sv
tb/sv/pulse_count_led_mode_sender_tb.sv
